### design/opta_pkg.sv
// Shared constants and types for the outer product tile accumulator.
// No dependencies; every other design file refers to it by scoped names.
package opta_pkg;

	localparam int TILE_ROWS      = 6;
	localparam int TILE_COLS      = 8;
	localparam int ELEMENT_BITS   = 16;
	localparam int SUM_BITS       = 48;
	localparam int A_PORT_BITS    = 16;
	localparam int B_PORT_BITS    = 64;
	localparam int LANES_PER_WORD = 4;
	localparam int ROW_IDX_BITS   = 3;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic clear;
	} lane_ctrl_t;

endpackage

### design/opta_lane.sv
// One accumulator lane: registered multiply, then saturating accumulate.
// Depends on opta_pkg for the lane control struct.
module opta_lane #(
	parameter int ELEMENT_BITS = opta_pkg::ELEMENT_BITS,
	parameter int SUM_BITS     = opta_pkg::SUM_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  opta_pkg::lane_ctrl_t        ctrl,
	input  logic signed [ELEMENT_BITS-1:0] a,
	input  logic signed [ELEMENT_BITS-1:0] b,
	output logic signed [SUM_BITS-1:0]  sum_nxt
);

	localparam int PROD_BITS = 2 * ELEMENT_BITS;

	logic signed [PROD_BITS-1:0] prod_s2;
	logic signed [SUM_BITS-1:0]  acc_q;
	logic signed [SUM_BITS:0]    wide;
	logic [SUM_BITS-1:0]         sat_max;
	logic [SUM_BITS-1:0]         sat_min;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= PROD_BITS'(a) * PROD_BITS'(b);
		end
	end

	assign sat_max = {1'b0, {(SUM_BITS-1){1'b1}}};
	assign sat_min = {1'b1, {(SUM_BITS-1){1'b0}}};

	always_comb begin
		wide = {acc_q[SUM_BITS-1], acc_q}
			+ {{(SUM_BITS+1-PROD_BITS){prod_s2[PROD_BITS-1]}}, prod_s2};
		if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
			sum_nxt = wide[SUM_BITS] ? sat_min : sat_max;
		end else begin
			sum_nxt = wide[SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= ctrl.clear ? '0 : sum_nxt;
		end
	end

endmodule

### design/opta_row_emit.sv
// Merging stage: captures the finished tile from all lanes and hands it out a row per beat.
// Depends on opta_pkg for tile shape and row index width.
module opta_row_emit #(
	parameter int SUM_BITS = opta_pkg::SUM_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [SUM_BITS-1:0]               load_sums [opta_pkg::TILE_ROWS][opta_pkg::TILE_COLS],
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [opta_pkg::ROW_IDX_BITS-1:0] row_index,
	output logic [SUM_BITS-1:0]               row_sums [opta_pkg::TILE_COLS],
	output logic                              last_row,
	output logic                              can_load
);

	localparam int ROWS = opta_pkg::TILE_ROWS;
	localparam int COLS = opta_pkg::TILE_COLS;

	logic [SUM_BITS-1:0]               rows_q [ROWS][COLS];
	logic [opta_pkg::ROW_IDX_BITS-1:0] row_q;
	logic                              full_q;
	logic                              fire;

	assign fire      = full_q && !out_stall;
	assign last_row  = (row_q == opta_pkg::ROW_IDX_BITS'(ROWS - 1));
	assign can_load  = !full_q || (fire && last_row);
	assign out_valid = full_q;
	assign row_index = row_q;
	assign row_sums  = rows_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			row_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			row_q  <= '0;
		end else if (fire) begin
			if (last_row) begin
				full_q <= 1'b0;
			end
			row_q <= row_q + 1'b1;
		end
	end

	// advance rows towards the head on each beat
	always_ff @(posedge clk) begin
		if (load) begin
			rows_q <= load_sums;
		end else if (fire) begin
			for (int r = 0; r < ROWS - 1; r++) begin
				rows_q[r] <= rows_q[r+1];
			end
		end
	end

endmodule

### design/outer_product_tile_accumulator_core.sv
// Top level of the 6x8 outer product tile accumulator.
// Depends on opta_pkg, opta_lane and opta_row_emit.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | a_row0..a_row5, b_cols_low, b_cols_high, last_depth
//  out     | out_valid/out_stall| row_index, sum_col0..sum_col7, last_row
//
// One depth step is accepted per cycle while in_stall is low; 48 lanes multiply in
// one stage and accumulate in the next: input register, product register, store.
// A last step loads the tile into the row emitter, which gives one row per beat:
// six beats per tile, so a tile shorter than six steps holds the input for the rest.
// Reset clears all accumulators and the emitter at once; no sweep follows.
// in_stall rises only while a finished tile waits for the emitter to drain.
module outer_product_tile_accumulator_core #(
	parameter int ELEMENT_BITS = opta_pkg::ELEMENT_BITS,
	parameter int SUM_BITS     = opta_pkg::SUM_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [opta_pkg::A_PORT_BITS-1:0] a_row0,
	input  logic signed [opta_pkg::A_PORT_BITS-1:0] a_row1,
	input  logic signed [opta_pkg::A_PORT_BITS-1:0] a_row2,
	input  logic signed [opta_pkg::A_PORT_BITS-1:0] a_row3,
	input  logic signed [opta_pkg::A_PORT_BITS-1:0] a_row4,
	input  logic signed [opta_pkg::A_PORT_BITS-1:0] a_row5,
	input  logic [opta_pkg::B_PORT_BITS-1:0]     b_cols_low,
	input  logic [opta_pkg::B_PORT_BITS-1:0]     b_cols_high,
	input  logic                                 last_depth,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [opta_pkg::ROW_IDX_BITS-1:0]    row_index,
	output logic signed [SUM_BITS-1:0]           sum_col0,
	output logic signed [SUM_BITS-1:0]           sum_col1,
	output logic signed [SUM_BITS-1:0]           sum_col2,
	output logic signed [SUM_BITS-1:0]           sum_col3,
	output logic signed [SUM_BITS-1:0]           sum_col4,
	output logic signed [SUM_BITS-1:0]           sum_col5,
	output logic signed [SUM_BITS-1:0]           sum_col6,
	output logic signed [SUM_BITS-1:0]           sum_col7,
	output logic                                 last_row
);

	localparam int ROWS = opta_pkg::TILE_ROWS;
	localparam int COLS = opta_pkg::TILE_COLS;
	localparam int LPW  = opta_pkg::LANES_PER_WORD;

	logic signed [ELEMENT_BITS-1:0] a_in [ROWS];
	logic signed [ELEMENT_BITS-1:0] b_in [COLS];
	logic signed [ELEMENT_BITS-1:0] a_s1 [ROWS];
	logic signed [ELEMENT_BITS-1:0] b_s1 [COLS];
	logic                           vld_s1;
	logic                           vld_s2;
	logic                           last_s2;
	logic                           hold;
	logic                           in_fire;
	logic                           can_load;
	opta_pkg::lane_ctrl_t           lane_ctrl;
	logic [SUM_BITS-1:0]            sum_nxt [ROWS][COLS];
	logic [SUM_BITS-1:0]            row_sums [COLS];

	assign a_in[0] = a_row0[ELEMENT_BITS-1:0];
	assign a_in[1] = a_row1[ELEMENT_BITS-1:0];
	assign a_in[2] = a_row2[ELEMENT_BITS-1:0];
	assign a_in[3] = a_row3[ELEMENT_BITS-1:0];
	assign a_in[4] = a_row4[ELEMENT_BITS-1:0];
	assign a_in[5] = a_row5[ELEMENT_BITS-1:0];

	for (genvar c = 0; c < COLS; c++) begin : g_bsel
		if (c < LPW) begin : g_low
			assign b_in[c] = b_cols_low[(c % LPW) * ELEMENT_BITS +: ELEMENT_BITS];
		end else begin : g_high
			assign b_in[c] = b_cols_high[(c % LPW) * ELEMENT_BITS +: ELEMENT_BITS];
		end
	end

	// hold the pipe while a finished tile cannot enter the emitter
	assign hold     = vld_s2 && last_s2 && !can_load;
	assign in_stall = hold;
	assign in_fire  = in_valid && !hold;

	assign lane_ctrl.mul_en = !hold && vld_s1;
	assign lane_ctrl.acc_en = !hold && vld_s2;
	assign lane_ctrl.clear  = last_s2;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_s1 <= a_in;
			b_s1 <= b_in;
		end
	end

	logic last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else if (!hold) begin
			vld_s1  <= in_fire;
			last_s1 <= in_fire && last_depth;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		for (genvar c = 0; c < COLS; c++) begin : g_col
			opta_lane #(
				.ELEMENT_BITS (ELEMENT_BITS),
				.SUM_BITS     (SUM_BITS)
			) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (lane_ctrl),
				.a       (a_s1[r]),
				.b       (b_s1[c]),
				.sum_nxt (sum_nxt[r][c])
			);
		end
	end

	opta_row_emit #(
		.SUM_BITS (SUM_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (lane_ctrl.acc_en && last_s2),
		.load_sums (sum_nxt),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.row_index (row_index),
		.row_sums  (row_sums),
		.last_row  (last_row),
		.can_load  (can_load)
	);

	assign sum_col0 = row_sums[0];
	assign sum_col1 = row_sums[1];
	assign sum_col2 = row_sums[2];
	assign sum_col3 = row_sums[3];
	assign sum_col4 = row_sums[4];
	assign sum_col5 = row_sums[5];
	assign sum_col6 = row_sums[6];
	assign sum_col7 = row_sums[7];

endmodule

### design/opta_chk.sv
// Port-level checker for the tile accumulator, bound to the top level.
// Depends on opta_pkg for the row index width and tile height.
module opta_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [opta_pkg::ROW_IDX_BITS-1:0] row_index,
	input logic                              last_row
);

	localparam logic [opta_pkg::ROW_IDX_BITS-1:0] LAST_IDX =
		opta_pkg::ROW_IDX_BITS'(opta_pkg::TILE_ROWS - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_index))
		else $error("row beat changed while stalled");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=>
			out_valid && (row_index == $past(row_index) + 1'b1))
		else $error("tile rows not in order");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (row_index == LAST_IDX)))
		else $error("last_row out of step with row_index");

	a_tile_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (row_index == '0))
		else $error("tile did not start at row zero");

endmodule

bind outer_product_tile_accumulator_core opta_chk u_opta_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row_index (row_index),
	.last_row  (last_row)
);
